[src/utt_pkg.sv]
// ----------------------------------------------------------------------------
// utt_pkg
// Shared types and constants of the UTF-8 to UTF-16 transcoder.
// ----------------------------------------------------------------------------
package utt_pkg;

    // Result status codes, as carried on the output tuser.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_RANGE    = 2'd2
    } t_status;

    // Input opcodes, as carried on the input tuser.
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_START = 1'b1;

    // Depth of the queue between the decoder and the emitter.
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam int unsigned POINT_W = 21;

    localparam logic [15:0]        BYTE_ORDER_MARK = 16'hFEFF;
    localparam logic [5:0]         SURR_HI_TAG     = 6'b110110;  // 0xD800 >> 10
    localparam logic [5:0]         SURR_LO_TAG     = 6'b110111;  // 0xDC00 >> 10
    localparam logic [POINT_W-1:0] SUPP_BASE       = 21'h010000;
    localparam logic [POINT_W-1:0] POINT_MAX       = 21'h10FFFF;

    // One classified event from the decoder: a finished code point or an error.
    typedef struct packed {
        logic               err;
        logic [POINT_W-1:0] point;
    } t_entry;

endpackage

[src/utt_front.sv]
// ----------------------------------------------------------------------------
// utt_front
// Byte decoder: tracks the pending continuation count and the partial code
// point, and pushes one event per byte that completes or breaks a sequence.
// ----------------------------------------------------------------------------
module utt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic                i_opcode,
    input  logic [7:0]          i_byte,
    output logic                o_push,
    output utt_pkg::t_entry     o_entry
);

    logic [1:0]                   r_pending;
    logic [utt_pkg::POINT_W-1:0]  r_partial;
    logic [1:0]                   n_pending;
    logic [utt_pkg::POINT_W-1:0]  n_partial;
    logic                         emit;
    utt_pkg::t_entry              entry;
    logic [utt_pkg::POINT_W-1:0]  shifted;

    assign shifted = {r_partial[utt_pkg::POINT_W-7:0], i_byte[5:0]};

    // Decode one byte against the current sequence state.
    always_comb begin
        n_pending   = r_pending;
        n_partial   = r_partial;
        emit        = 1'b0;
        entry.err   = 1'b0;
        entry.point = r_partial;
        if (i_opcode == utt_pkg::OP_START) begin
            emit        = 1'b1;
            entry.point = {5'd0, utt_pkg::BYTE_ORDER_MARK};
            n_pending   = 2'd0;
            n_partial   = '0;
        end else if (r_pending != 2'd0) begin
            if (i_byte[7:6] != 2'b10) begin
                // A non-continuation byte ends the sequence early and is dropped.
                emit      = 1'b1;
                n_pending = 2'd0;
                n_partial = '0;
            end else if (r_pending == 2'd1) begin
                emit        = 1'b1;
                entry.point = shifted;
                n_pending   = 2'd0;
                n_partial   = '0;
            end else begin
                n_pending = r_pending - 2'd1;
                n_partial = shifted;
            end
        end else begin
            case (i_byte[7:3]) inside
                [5'b00000:5'b01111]: begin
                    emit        = 1'b1;
                    entry.point = {13'd0, i_byte};
                end
                [5'b11000:5'b11011]: begin
                    n_pending = 2'd1;
                    n_partial = {16'd0, i_byte[4:0]};
                end
                [5'b11100:5'b11101]: begin
                    n_pending = 2'd2;
                    n_partial = {17'd0, i_byte[3:0]};
                end
                5'b11110: begin
                    n_pending = 2'd3;
                    n_partial = {18'd0, i_byte[2:0]};
                end
                default: begin
                    // Stray continuation byte or a lead of 0xF8 and above.
                    emit        = 1'b1;
                    entry.err   = 1'b1;
                    entry.point = '0;
                    n_pending   = 2'd0;
                    n_partial   = '0;
                end
            endcase
        end
    end

    assign o_push  = i_accept && emit;
    assign o_entry = entry;

    // Sequence state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= 2'd0;
            r_partial <= '0;
        end else if (i_accept) begin
            r_pending <= n_pending;
            r_partial <= n_partial;
        end
    end

endmodule

[src/utt_queue.sv]
// ----------------------------------------------------------------------------
// utt_queue
// Short first-in first-out queue of decoded events between the decoder and
// the emitter.
// ----------------------------------------------------------------------------
module utt_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  utt_pkg::t_entry   i_entry,
    input  logic              i_pop,
    output utt_pkg::t_entry   o_entry,
    output logic              o_full,
    output logic              o_empty
);

    utt_pkg::t_entry              r_mem [utt_pkg::QUEUE_DEPTH];
    logic [utt_pkg::QUEUE_AW-1:0] r_wr_ptr;
    logic [utt_pkg::QUEUE_AW-1:0] r_rd_ptr;
    logic [utt_pkg::QUEUE_AW:0]   r_count;
    logic                         do_push;
    logic                         do_pop;

    assign o_full  = (r_count == (utt_pkg::QUEUE_AW+1)'(utt_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_entry = r_mem[r_rd_ptr];

    // Storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

[src/utt_back.sv]
// ----------------------------------------------------------------------------
// utt_back
// Emitter: turns each decoded event into one or two UTF-16 results and holds
// them in the output register until the receiver takes them.
// ----------------------------------------------------------------------------
module utt_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  utt_pkg::t_entry   i_entry,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [15:0]       o_unit,
    output utt_pkg::t_status  o_status,
    output logic              o_last
);

    logic                        r_valid;
    logic [15:0]                 r_unit;
    utt_pkg::t_status            r_status;
    logic                        r_last;
    logic                        r_low_pend;
    logic [9:0]                  r_low;
    logic                        load;
    logic [utt_pkg::POINT_W-1:0] offset;

    assign load   = !r_valid || i_ready;
    assign o_pop  = load && !r_low_pend && !i_empty;
    assign offset = i_entry.point - utt_pkg::SUPP_BASE;

    // Output register and the pending low surrogate.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_low_pend <= 1'b0;
        end else if (load) begin
            if (r_low_pend) begin
                r_valid    <= 1'b1;
                r_unit     <= {utt_pkg::SURR_LO_TAG, r_low};
                r_status   <= utt_pkg::ST_OK;
                r_last     <= 1'b1;
                r_low_pend <= 1'b0;
            end else if (!i_empty) begin
                r_valid <= 1'b1;
                if (i_entry.err) begin
                    r_unit   <= 16'd0;
                    r_status <= utt_pkg::ST_BAD_LEAD;
                    r_last   <= 1'b1;
                end else if (i_entry.point[utt_pkg::POINT_W-1:16] == '0) begin
                    r_unit   <= i_entry.point[15:0];
                    r_status <= utt_pkg::ST_OK;
                    r_last   <= 1'b1;
                end else if (i_entry.point <= utt_pkg::POINT_MAX) begin
                    r_unit     <= {utt_pkg::SURR_HI_TAG, offset[19:10]};
                    r_status   <= utt_pkg::ST_OK;
                    r_last     <= 1'b0;
                    r_low_pend <= 1'b1;
                    r_low      <= offset[9:0];
                end else begin
                    r_unit   <= 16'd0;
                    r_status <= utt_pkg::ST_RANGE;
                    r_last   <= 1'b1;
                end
            end else begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_valid  = r_valid;
    assign o_unit   = r_unit;
    assign o_status = r_status;
    assign o_last   = r_last;

endmodule

[src/utf8_to_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// Streams UTF-8 bytes in and UTF-16 code units out.
// ----------------------------------------------------------------------------
// Input channel: one item per byte. tuser is the opcode (0 data byte,
// 1 start: emit the byte order mark 0xFEFF and clear the decoder state);
// tdata is the byte, ignored for start.
// Output channel: tdata is a UTF-16 code unit, tuser is the status (0 ok,
// 1 invalid lead byte, 2 code point above 0x10FFFF, unit zero for both),
// tlast marks the final result of the input item that caused it.
// A code point above 0xFFFF up to 0x10FFFF gives two items, high then low surrogate.
// Throughput: one input item per cycle unless the queue is full, one output
// item per cycle while the receiver is ready. A four-entry queue joins the
// decoder and emitter and absorbs the extra low surrogate of a pair; a run
// of pairs settles at one input byte per cycle on average as long as each
// pair takes four bytes. Items pass the queue, then the output register.
// When the receiver stalls, the output register holds its item and the queue
// fills; tready drops only while the queue is full.
// Reset (synchronous, active low) clears the sequence state, the queue and
// the output register.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] byte_in
    input  logic        i_s_axis_tuser,   // [0] opcode
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [15:0] o_m_axis_tdata,   // [15:0] code_unit
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    output logic        o_m_axis_tlast
);

    logic             in_accept;
    logic             push;
    utt_pkg::t_entry  push_entry;
    utt_pkg::t_entry  head_entry;
    logic             pop;
    logic             q_full;
    logic             q_empty;
    utt_pkg::t_status status;

    assign o_s_axis_tready = !q_full;
    assign in_accept       = i_s_axis_tvalid && !q_full;

    // Front: byte decoder.
    utt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_opcode (i_s_axis_tuser),
        .i_byte   (i_s_axis_tdata),
        .o_push   (push),
        .o_entry  (push_entry)
    );

    // Queue between decoder and emitter.
    utt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .i_pop   (pop),
        .o_entry (head_entry),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Back: UTF-16 emitter with output register.
    utt_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_entry  (head_entry),
        .i_empty  (q_empty),
        .o_pop    (pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_unit   (o_m_axis_tdata),
        .o_status (status),
        .o_last   (o_m_axis_tlast)
    );

    assign o_m_axis_tuser = status;

`ifndef SYNTHESIS
    // An error result always carries a zero code unit.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != utt_pkg::ST_OK) |-> (o_m_axis_tdata == 16'd0))
        else $error("error result with nonzero code unit");

    // A result that is not the last of its item is always a high surrogate.
    a_first_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !o_m_axis_tlast) |->
        (o_m_axis_tdata[15:10] == utt_pkg::SURR_HI_TAG))
        else $error("non-final result is not a high surrogate");

    // Once a high surrogate is taken, the low surrogate follows right away.
    a_low_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast) |=>
        (o_m_axis_tvalid && o_m_axis_tlast &&
         o_m_axis_tdata[15:10] == utt_pkg::SURR_LO_TAG))
        else $error("low surrogate did not follow high surrogate");
`endif

endmodule

[test/tb_utf8_to_utf16_transcoder.sv]
// ----------------------------------------------------------------------------
// tb_utf8_to_utf16_transcoder
// Self-checking testbench for the UTF-8 to UTF-16 transcoder. A directed set
// of byte sequences covers the field extremes and the error and truncation
// cases. After that, mostly well-formed random UTF-8 characters are mixed
// with noise bytes, start items and broken sequences. A tracker class
// predicts the UTF-16 units for each accepted input item and checks every
// accepted output item, in order, against them. Both sides idle at random,
// and once the receiver stalls long enough to back up the input.
// ----------------------------------------------------------------------------

// One expected output item of the transcoder.
typedef struct packed {
    logic [15:0]       unit;
    utt_pkg::t_status  status;
    logic              last;
} utf16_unit_t;

// Tracks the decoder state on its own and holds the units still to come.
class utf16_unit_tracker;

    localparam logic [20:0] BMP_END    = 21'h010000;
    localparam logic [20:0] POINT_END  = 21'h110000;
    localparam logic [15:0] HIGH_SURR  = 16'hD800;
    localparam logic [15:0] LOW_SURR   = 16'hDC00;
    localparam int          PRINT_MAX  = 40;

    logic [1:0]   cont_left;
    logic [20:0]  point_acc;
    utf16_unit_t  expected_units[$];
    int           errors;

    function new();
        cont_left = '0;
        point_acc = '0;
        errors    = 0;
    endfunction

    function int outstanding();
        return expected_units.size();
    endfunction

    function void push_unit(logic [15:0] unit, utt_pkg::t_status status, logic last);
        utf16_unit_t u;
        u.unit   = unit;
        u.status = status;
        u.last   = last;
        expected_units.push_back(u);
    endfunction

    // A finished code point: one BMP unit, a surrogate pair, or a range error.
    function void finish_point(logic [20:0] c);
        logic [20:0] v;
        cont_left = '0;
        point_acc = '0;
        if (c < BMP_END) begin
            push_unit(c[15:0], utt_pkg::ST_OK, 1'b1);
        end else if (c < POINT_END) begin
            v = c - BMP_END;
            push_unit(HIGH_SURR | {6'd0, v[19:10]}, utt_pkg::ST_OK, 1'b0);
            push_unit(LOW_SURR | {6'd0, v[9:0]}, utt_pkg::ST_OK, 1'b1);
        end else begin
            push_unit(16'h0000, utt_pkg::ST_RANGE, 1'b1);
        end
    endfunction

    function void bad_lead();
        cont_left = '0;
        point_acc = '0;
        push_unit(16'h0000, utt_pkg::ST_BAD_LEAD, 1'b1);
    endfunction

    // Works out the units caused by one accepted input item.
    function void note_byte(logic op, logic [7:0] b);
        if (op == utt_pkg::OP_START) begin
            cont_left = '0;
            point_acc = '0;
            push_unit(utt_pkg::BYTE_ORDER_MARK, utt_pkg::ST_OK, 1'b1);
            return;
        end
        // Inside a sequence: a non-continuation byte is dropped and the
        // partial point goes out as it stands.
        if (cont_left != 2'd0) begin
            if (b[7:6] != 2'b10) begin
                finish_point(point_acc);
                return;
            end
            point_acc = {point_acc[14:0], b[5:0]};
            cont_left = cont_left - 2'd1;
            if (cont_left == 2'd0) finish_point(point_acc);
            return;
        end
        // Lead position.
        if (b < 8'h80) begin
            finish_point({13'd0, b});
        end else if (b < 8'hC0) begin
            bad_lead();
        end else if (b < 8'hE0) begin
            point_acc = {16'd0, b[4:0]};
            cont_left = 2'd1;
        end else if (b < 8'hF0) begin
            point_acc = {17'd0, b[3:0]};
            cont_left = 2'd2;
        end else if (b < 8'hF8) begin
            point_acc = {18'd0, b[2:0]};
            cont_left = 2'd3;
        end else begin
            bad_lead();
        end
    endfunction

    task report(string msg);
        if (errors < PRINT_MAX) $display("MISMATCH: %s", msg);
        errors++;
    endtask

    // Compares one accepted output item with the oldest expected unit.
    task check_unit(logic [15:0] unit, logic [1:0] status, logic last);
        utf16_unit_t e;
        if (expected_units.size() == 0) begin
            report($sformatf("unexpected item unit %h status %0d last %0d",
                             unit, status, last));
            return;
        end
        e = expected_units.pop_front();
        if (unit !== e.unit)
            report($sformatf("unit %h, expected %h", unit, e.unit));
        if (status !== e.status)
            report($sformatf("status %0d, expected %0d (unit %h)", status, e.status, e.unit));
        if (last !== e.last)
            report($sformatf("last %0d, expected %0d (unit %h)", last, e.last, e.unit));
    endtask

endclass

module tb_utf8_to_utf16_transcoder;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 10;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic [7:0]  s_data = 8'h00;              // [7:0] byte_in
    logic        s_user = utt_pkg::OP_DATA;   // [0] opcode
    logic        s_ready;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_data;                      // [15:0] code_unit
    logic [1:0]  m_user;                      // [1:0] status
    logic        m_last;

    utf16_unit_tracker tracker = new();

    int items_sent = 0;
    int cycle_count = 0;
    int send_burst_left = 0;
    bit send_fast = 1'b0;
    bit hold_armed = 1'b0;

    utf8_to_utf16_transcoder i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user),
        .o_m_axis_tlast  (m_last)
    );

    // Free-running clock.
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Run length guard.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL utf8_to_utf16_transcoder");
            $finish;
        end
    end

    // Every accepted input item goes to the predictor.
    always @(posedge i_clk) begin
        if (i_rst_n && s_valid && s_ready) tracker.note_byte(s_user, s_data);
    end

    // Every accepted output item is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) tracker.check_unit(m_data, m_user, m_last);
    end

    // Offers one input item after a random gap and waits for its acceptance.
    // Called and returning at a falling edge.
    task drive_byte(logic op, logic [7:0] b);
        int gap;
        if (send_burst_left == 0) begin
            send_burst_left = $urandom_range(10, 40);
            send_fast = ($urandom_range(0, 2) == 0);
        end
        send_burst_left--;
        gap = send_fast ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_data  <= b;
        s_user  <= op;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        items_sent++;
        @(negedge i_clk);
    endtask

    function logic [7:0] cont_byte();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // One random character, mostly well formed, sometimes noise or broken.
    task send_random_char();
        int kind;
        int len;
        int cut;
        logic [7:0] lead;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            drive_byte(utt_pkg::OP_DATA, 8'($urandom_range(0, 127)));
        end else if (kind < 80) begin
            if (kind < 35) begin
                len  = 2;
                lead = {3'b110, 5'($urandom_range(0, 31))};
            end else if (kind < 55) begin
                len  = 3;
                lead = {4'b1110, 4'($urandom_range(0, 15))};
            end else begin
                len  = 4;
                // Leads above 0xF4 give out-of-range points; keep them rarer.
                lead = {5'b11110, 3'(($urandom_range(0, 9) < 7) ?
                                    $urandom_range(0, 4) : $urandom_range(5, 7))};
            end
            drive_byte(utt_pkg::OP_DATA, lead);
            repeat (len - 1) drive_byte(utt_pkg::OP_DATA, cont_byte());
        end else if (kind < 87) begin
            drive_byte(utt_pkg::OP_START, 8'($urandom_range(0, 255)));
        end else if (kind < 93) begin
            drive_byte(utt_pkg::OP_DATA, 8'($urandom_range(0, 255)));
        end else begin
            // Truncated sequence ended by an ASCII byte, a lead byte or a start.
            len = $urandom_range(2, 4);
            cut = $urandom_range(0, len - 2);
            case (len)
                2: lead = {3'b110, 5'($urandom_range(0, 31))};
                3: lead = {4'b1110, 4'($urandom_range(0, 15))};
                default: lead = {5'b11110, 3'($urandom_range(0, 7))};
            endcase
            drive_byte(utt_pkg::OP_DATA, lead);
            repeat (cut) drive_byte(utt_pkg::OP_DATA, cont_byte());
            if ($urandom_range(0, 4) == 0) begin
                drive_byte(utt_pkg::OP_START, 8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 1) == 0) begin
                drive_byte(utt_pkg::OP_DATA, 8'($urandom_range(0, 127)));
            end else begin
                drive_byte(utt_pkg::OP_DATA, 8'($urandom_range(192, 255)));
            end
        end
    endtask

    // Receiver: random stalls per item, bursts without stalls, and one long
    // hold-off that backs the block up.
    initial begin
        int stall;
        int burst_left;
        bit fast;
        burst_left = 0;
        fast = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(10, 40);
                fast = ($urandom_range(0, 2) == 0);
            end
            burst_left--;
            stall = fast ? 0 : $urandom_range(0, 15);
            if (hold_armed) begin
                hold_armed = 1'b0;
                stall = HOLD_CYCLES;
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            m_ready <= 1'b1;
            @(posedge i_clk);
            while (!m_valid) @(posedge i_clk);
            @(negedge i_clk);
        end
    end

    // Main sequence: reset, directed cases, random stream, drain.
    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Start item, ASCII extremes, stray continuation and invalid leads.
        drive_byte(utt_pkg::OP_START, 8'hFF);
        drive_byte(utt_pkg::OP_DATA, 8'h00);
        drive_byte(utt_pkg::OP_DATA, 8'h7F);
        drive_byte(utt_pkg::OP_DATA, 8'h80);
        drive_byte(utt_pkg::OP_DATA, 8'hFF);
        drive_byte(utt_pkg::OP_DATA, 8'hF8);
        // Two-byte and the highest three-byte form.
        drive_byte(utt_pkg::OP_DATA, 8'hC2);
        drive_byte(utt_pkg::OP_DATA, 8'hA9);
        drive_byte(utt_pkg::OP_DATA, 8'hEF);
        drive_byte(utt_pkg::OP_DATA, 8'hBF);
        drive_byte(utt_pkg::OP_DATA, 8'hBF);
        // Highest valid point as a surrogate pair, then one past it.
        drive_byte(utt_pkg::OP_DATA, 8'hF4);
        drive_byte(utt_pkg::OP_DATA, 8'h8F);
        drive_byte(utt_pkg::OP_DATA, 8'hBF);
        drive_byte(utt_pkg::OP_DATA, 8'hBF);
        drive_byte(utt_pkg::OP_DATA, 8'hF4);
        drive_byte(utt_pkg::OP_DATA, 8'h90);
        drive_byte(utt_pkg::OP_DATA, 8'h80);
        drive_byte(utt_pkg::OP_DATA, 8'h80);
        // Sequence cut by an ASCII byte, and one cut by a start item.
        drive_byte(utt_pkg::OP_DATA, 8'hE2);
        drive_byte(utt_pkg::OP_DATA, 8'h41);
        drive_byte(utt_pkg::OP_DATA, 8'hF0);
        drive_byte(utt_pkg::OP_DATA, 8'h9F);
        drive_byte(utt_pkg::OP_START, 8'h00);

        // Random stream, with one long receiver hold-off early on.
        hold_armed = 1'b1;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) send_random_char();
        s_valid <= 1'b0;

        while (tracker.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.errors == 0) begin
            $display("PASS utf8_to_utf16_transcoder");
        end else begin
            $display("FAIL utf8_to_utf16_transcoder");
        end
        $finish;
    end

endmodule
